[hw/rtl/rsht_pkg.sv]
// Shared constants and types for the ray/sphere hit test unit.
`timescale 1ns / 1ps
package rsht_pkg;
	localparam int POS_W = 24;
	localparam int RAD_W = 23;
	localparam int DIR_W = 18;
	localparam int IDX_W = 3;
	localparam int L_W = POS_W + 1;
	localparam int A_W = 2 * DIR_W + 2;
	localparam int B_W = DIR_W + L_W + 3;
	localparam int C_W = 2 * L_W + 3;
	localparam int SQ_W = 2 * B_W + 2;
	localparam int B_HALF = B_W / 2;
	localparam int P_W = A_W + C_W + 2;
	localparam int N_CELLS = 3;

	localparam logic [IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd3;
	localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd4;
	localparam logic [IDX_W-1:0] REG_CENTER_Z = 3'd5;
	localparam logic [IDX_W-1:0] REG_RADIUS = 3'd6;

	typedef struct packed {
		logic signed [A_W-1:0] a;
		logic signed [B_W-1:0] b;
	} acc_t;
endpackage

[hw/rtl/rsht_dot_cell.sv]
// One cell of the dot-product chain: adds one axis term to the running sums.
`timescale 1ns / 1ps
module rsht_dot_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_in,
	input  logic signed [rsht_pkg::DIR_W-1:0] d,
	input  logic signed [rsht_pkg::L_W-1:0] l,
	input  rsht_pkg::acc_t acc_in,
	output rsht_pkg::acc_t acc_out,
	output logic valid_out
);
	logic signed [2*rsht_pkg::DIR_W-1:0] dd;
	logic signed [rsht_pkg::DIR_W+rsht_pkg::L_W-1:0] dl;
	rsht_pkg::acc_t acc_q;
	logic valid_q;

	assign dd = d * d;
	assign dl = d * l;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q.a <= acc_in.a + rsht_pkg::A_W'(dd);
			acc_q.b <= acc_in.b + rsht_pkg::B_W'(dl);
		end
	end

	assign acc_out = acc_q;
	assign valid_out = valid_q;
endmodule

[hw/rtl/rsht_decide.sv]
// Final stages: squares b, forms 4ac and decides the hit flag.
`timescale 1ns / 1ps
module rsht_decide (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_in,
	input  rsht_pkg::acc_t acc_in,
	input  logic signed [rsht_pkg::C_W-1:0] c,
	output logic valid_out,
	output logic hit
);
	logic [rsht_pkg::B_W-1:0] mb;
	logic [rsht_pkg::B_W-1:0] mb_s1;
	logic [rsht_pkg::A_W-1:0] a_s1;
	logic [rsht_pkg::C_W-1:0] c_s1;
	logic apos_s1, cle_s1, bpos_s1, valid_s1;
	logic [2*rsht_pkg::B_W-1:0] ll_s2, lh_s2, hh_s2;
	logic [rsht_pkg::P_W-1:0] p_s2;
	logic apos_s2, cle_s2, bpos_s2, valid_s2;
	logic [rsht_pkg::SQ_W-1:0] sq;
	logic [rsht_pkg::A_W+rsht_pkg::C_W-1:0] ac_lo, ac_hi;
	logic hit_q, valid_q;

	assign mb = rsht_pkg::B_W'(-acc_in.b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_q <= valid_s2;
		end
	end

	assign ac_lo = a_s1 * c_s1[rsht_pkg::B_HALF-1:0];
	assign ac_hi = a_s1 * (c_s1 >> rsht_pkg::B_HALF);

	always_ff @(posedge clk) begin
		if (en) begin
			mb_s1 <= mb;
			a_s1 <= rsht_pkg::A_W'(acc_in.a);
			c_s1 <= rsht_pkg::C_W'(c);
			apos_s1 <= acc_in.a > 0;
			cle_s1 <= c <= 0;
			bpos_s1 <= acc_in.b > 0;
			ll_s2 <= (2*rsht_pkg::B_W)'(mb_s1[rsht_pkg::B_HALF-1:0]
				* mb_s1[rsht_pkg::B_HALF-1:0]);
			lh_s2 <= (2*rsht_pkg::B_W)'(mb_s1[rsht_pkg::B_HALF-1:0]
				* (mb_s1 >> rsht_pkg::B_HALF));
			hh_s2 <= (2*rsht_pkg::B_W)'((mb_s1 >> rsht_pkg::B_HALF)
				* (mb_s1 >> rsht_pkg::B_HALF));
			p_s2 <= (rsht_pkg::P_W'(ac_lo) + (rsht_pkg::P_W'(ac_hi) << rsht_pkg::B_HALF)) << 2;
			apos_s2 <= apos_s1;
			cle_s2 <= cle_s1;
			bpos_s2 <= bpos_s1;
			hit_q <= apos_s2 && (cle_s2 || (!bpos_s2 && (sq >= rsht_pkg::SQ_W'(p_s2))));
		end
	end

	assign sq = rsht_pkg::SQ_W'(ll_s2) + (rsht_pkg::SQ_W'(lh_s2) << (rsht_pkg::B_HALF + 1))
		+ (rsht_pkg::SQ_W'(hh_s2) << (2 * rsht_pkg::B_HALF));
	assign hit = hit_q;
	assign valid_out = valid_q;
endmodule

[hw/rtl/ray_sphere_hit_test_unit.sv]
// Top level of the ray/sphere hit test unit.
`timescale 1ns / 1ps
// Throughput: one ray per cycle while the output is not stalled, through a three-cell
// dot-product chain followed by a three-stage square-and-compare unit.
// Reset clears all valid flags and loads the default origin, center and radius.
// The whole pipeline advances whenever the output register is free or taken.
module ray_sphere_hit_test_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [rsht_pkg::IDX_W-1:0] cfg_index,
	input  logic [rsht_pkg::POS_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [rsht_pkg::DIR_W-1:0] dir_x,
	input  logic signed [rsht_pkg::DIR_W-1:0] dir_y,
	input  logic signed [rsht_pkg::DIR_W-1:0] dir_z,
	output logic out_valid,
	input  logic out_ready,
	output logic hit
);
	logic signed [rsht_pkg::POS_W-1:0] pos_q [6];
	logic [rsht_pkg::RAD_W-1:0] radius_q;
	logic signed [rsht_pkg::L_W-1:0] l [rsht_pkg::N_CELLS];
	logic signed [rsht_pkg::C_W-1:0] c_q;
	logic signed [rsht_pkg::DIR_W-1:0] dy_s1, dz_s1, dz_s2;
	rsht_pkg::acc_t acc [rsht_pkg::N_CELLS+1];
	rsht_pkg::acc_t acc_dec;
	logic vld [rsht_pkg::N_CELLS+1];
	logic en;

	assign cfg_ready = 1'b1;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q[rsht_pkg::REG_ORIGIN_X] <= '0;
			pos_q[rsht_pkg::REG_ORIGIN_Y] <= '0;
			pos_q[rsht_pkg::REG_ORIGIN_Z] <= '0;
			pos_q[rsht_pkg::REG_CENTER_X] <= '0;
			pos_q[rsht_pkg::REG_CENTER_Y] <= '0;
			pos_q[rsht_pkg::REG_CENTER_Z] <= rsht_pkg::POS_W'(655360);
			radius_q <= rsht_pkg::RAD_W'(131072);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rsht_pkg::REG_ORIGIN_X, rsht_pkg::REG_ORIGIN_Y, rsht_pkg::REG_ORIGIN_Z,
				rsht_pkg::REG_CENTER_X, rsht_pkg::REG_CENTER_Y,
				rsht_pkg::REG_CENTER_Z: pos_q[cfg_index] <= cfg_data;
				rsht_pkg::REG_RADIUS: radius_q <= cfg_data[rsht_pkg::RAD_W-1:0];
				default: ;
			endcase
		end
	end

	for (genvar k = 0; k < rsht_pkg::N_CELLS; k++) begin : g_l
		assign l[k] = rsht_pkg::L_W'(pos_q[k]) - rsht_pkg::L_W'(pos_q[k+3]);
	end

	// User keeps configuration stable while items flow (unchecked); c is registered.
	always_ff @(posedge clk) begin
		c_q <= rsht_pkg::C_W'(l[0] * l[0]) + rsht_pkg::C_W'(l[1] * l[1])
			+ rsht_pkg::C_W'(l[2] * l[2]) - rsht_pkg::C_W'(radius_q * radius_q);
		if (en) begin
			dy_s1 <= dir_y;
			dz_s1 <= dir_z;
			dz_s2 <= dz_s1;
		end
	end

	assign acc[0] = '0;
	assign vld[0] = in_valid;

	rsht_dot_cell u_cell0 (.clk, .arst_n, .en, .valid_in(vld[0]), .d(dir_x), .l(l[0]),
		.acc_in(acc[0]), .acc_out(acc[1]), .valid_out(vld[1]));
	rsht_dot_cell u_cell1 (.clk, .arst_n, .en, .valid_in(vld[1]), .d(dy_s1), .l(l[1]),
		.acc_in(acc[1]), .acc_out(acc[2]), .valid_out(vld[2]));
	rsht_dot_cell u_cell2 (.clk, .arst_n, .en, .valid_in(vld[2]), .d(dz_s2), .l(l[2]),
		.acc_in(acc[2]), .acc_out(acc[3]), .valid_out(vld[3]));

	assign acc_dec.a = acc[3].a;
	assign acc_dec.b = acc[3].b <<< 1;

	rsht_decide u_decide (.clk, .arst_n, .en, .valid_in(vld[3]),
		.acc_in(acc_dec), .c(c_q),
		.valid_out(out_valid), .hit);
endmodule

[sim/tb.sv]
// Testbench for the ray/sphere hit test unit: directed table, random rays, exact predictor.
`timescale 1ns / 1ps
module tb;
	typedef struct {
		logic signed [rsht_pkg::DIR_W-1:0] dx;
		logic signed [rsht_pkg::DIR_W-1:0] dy;
		logic signed [rsht_pkg::DIR_W-1:0] dz;
		int want;
	} ray_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [rsht_pkg::IDX_W-1:0] cfg_index = '0;
	logic [rsht_pkg::POS_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [rsht_pkg::DIR_W-1:0] dir_x = '0;
	logic signed [rsht_pkg::DIR_W-1:0] dir_y = '0;
	logic signed [rsht_pkg::DIR_W-1:0] dir_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;

	logic [rsht_pkg::POS_W-1:0] sph_regs [0:6];
	bit expected_hits [$];
	int errors = 0;
	bit quiet = 1'b0;
	int long_hold = 0;
	bit rx_done = 1'b0;

	ray_sphere_hit_test_unit dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit hit_of(logic signed [rsht_pkg::DIR_W-1:0] dx,
			logic signed [rsht_pkg::DIR_W-1:0] dy, logic signed [rsht_pkg::DIR_W-1:0] dz);
		logic signed [127:0] d [3];
		logic signed [127:0] l [3];
		logic signed [127:0] a, b, c, r;
		d[0] = dx; d[1] = dy; d[2] = dz;
		a = 0; b = 0; c = 0;
		for (int i = 0; i < 3; i++) begin
			l[i] = $signed(sph_regs[i]) - $signed(sph_regs[3 + i]);
			a += d[i] * d[i];
			b += d[i] * l[i];
			c += l[i] * l[i];
		end
		b = 2 * b;
		r = {1'b0, sph_regs[6][rsht_pkg::RAD_W-1:0]};
		c -= r * r;
		if (a <= 0) return 1'b0;
		if (c <= 0) return 1'b1;
		if (b > 0) return 1'b0;
		return b * b >= 4 * a * c;
	endfunction

	task automatic write_reg(logic [rsht_pkg::IDX_W-1:0] idx, logic [rsht_pkg::POS_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		if (idx <= rsht_pkg::REG_CENTER_Z) sph_regs[idx] = val;
		else if (idx == rsht_pkg::REG_RADIUS) sph_regs[idx] = {1'b0, val[rsht_pkg::RAD_W-1:0]};
	endtask

	task automatic send_ray(logic signed [rsht_pkg::DIR_W-1:0] dx,
			logic signed [rsht_pkg::DIR_W-1:0] dy, logic signed [rsht_pkg::DIR_W-1:0] dz,
			int want);
		bit exp_hit;
		cfg_valid <= 1'b0;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		exp_hit = hit_of(dx, dy, dz);
		if (want >= 0 && exp_hit != want[0]) begin
			$display("%0t predictor disagrees with table: expected %0d actual %0d",
				$time, want, exp_hit);
			errors++;
		end
		dir_x <= dx;
		dir_y <= dy;
		dir_z <= dz;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_hits.push_back(want >= 0 ? want[0] : exp_hit);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (expected_hits.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	function automatic logic [rsht_pkg::DIR_W-1:0] rand_dir();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 1) ? 18'h1ffff : 18'h20000;
			1: return rsht_pkg::DIR_W'($urandom_range(0, 3) - 2);
			default: return rsht_pkg::DIR_W'($urandom);
		endcase
	endfunction

	function automatic logic [rsht_pkg::POS_W-1:0] rand_pos();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
			1: return rsht_pkg::POS_W'($urandom_range(0, 2000) - 1000);
			default: return rsht_pkg::POS_W'($urandom);
		endcase
	endfunction

	// Receiver: random stalls, one long hold-off to fill the pipeline.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold > 0) begin
				out_ready <= 1'b0;
				repeat (long_hold) @(negedge clk);
				long_hold = 0;
			end
			if (!quiet && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 14);
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_hits.size() == 0) begin
				$display("%0t unexpected transfer: expected none actual hit=%0d", $time, hit);
				errors++;
			end else begin
				bit e;
				e = expected_hits.pop_front();
				if (hit !== e) begin
					$display("%0t hit mismatch: expected %0d actual %0d", $time, e, hit);
					errors++;
				end
			end
		end
	end

	initial begin
		ray_row_t table_rows [$];
		for (int i = 0; i < 7; i++) sph_regs[i] = '0;
		sph_regs[rsht_pkg::REG_CENTER_Z] = 24'd655360;
		sph_regs[rsht_pkg::REG_RADIUS] = 24'd131072;
		table_rows = '{
			'{18'sd0, 18'sd0, 18'sd0, 0},
			'{18'sd0, 18'sd0, 18'sd65536, 1},
			'{18'sd0, 18'sd0, -18'sd65536, 0},
			'{18'sd65536, 18'sd0, 18'sd0, 0},
			'{18'sd0, 18'sd0, 18'sd131071, 1},
			'{18'sd0, 18'sd0, -18'sd131072, 0},
			'{-18'sd131072, -18'sd131072, -18'sd131072, 0},
			'{18'sd131071, 18'sd131071, 18'sd131071, -1},
			'{18'sd13107, 18'sd0, 18'sd65536, -1},
			'{18'sd13107, 18'sd13107, 18'sd65536, -1},
			'{18'sd0, 18'sd1, 18'sd5, -1},
			'{18'sd1, 18'sd0, 18'sd0, 0},
			'{18'sd0, 18'sd0, 18'sd1, 1}
		};
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (table_rows[i])
			send_ray(table_rows[i].dx, table_rows[i].dy, table_rows[i].dz, table_rows[i].want);
		drain();
		// Tangent ray: sphere center (2,0,10) radius 2, ray along z.
		write_reg(rsht_pkg::REG_CENTER_X, 24'd131072);
		send_ray(18'sd0, 18'sd0, 18'sd65536, 1);
		send_ray(18'sd0, 18'sd0, -18'sd65536, 0);
		drain();
		// Origin inside the sphere: any nonzero direction hits; bad index ignored.
		write_reg(rsht_pkg::REG_ORIGIN_X, 24'd131072);
		write_reg(rsht_pkg::REG_ORIGIN_Y, 24'd0);
		write_reg(rsht_pkg::REG_ORIGIN_Z, 24'd655360);
		write_reg(3'd7, 24'hffffff);
		send_ray(18'sd0, -18'sd1, 18'sd0, 1);
		send_ray(18'sd0, 18'sd0, 18'sd0, 0);
		drain();
		// Extreme registers.
		write_reg(rsht_pkg::REG_ORIGIN_X, 24'h7fffff);
		write_reg(rsht_pkg::REG_ORIGIN_Y, 24'h800000);
		write_reg(rsht_pkg::REG_ORIGIN_Z, 24'h7fffff);
		write_reg(rsht_pkg::REG_CENTER_X, 24'h800000);
		write_reg(rsht_pkg::REG_CENTER_Y, 24'h7fffff);
		write_reg(rsht_pkg::REG_CENTER_Z, 24'h800000);
		write_reg(rsht_pkg::REG_RADIUS, 24'h7fffff);
		send_ray(-18'sd131072, 18'sd131071, -18'sd131072, -1);
		send_ray(18'sd131071, -18'sd131072, 18'sd131071, -1);
		drain();
		write_reg(rsht_pkg::REG_RADIUS, 24'h0);
		send_ray(-18'sd131072, 18'sd131071, -18'sd131072, -1);
		drain();
		long_hold = 60;
		for (int ph = 0; ph < 10; ph++) begin
			for (int k = 0; k < 7; k++) begin
				logic [rsht_pkg::POS_W-1:0] v;
				v = rand_pos();
				if (k == rsht_pkg::REG_RADIUS && $urandom_range(0, 1))
					v = rsht_pkg::POS_W'($urandom_range(0, 400000));
				write_reg(k[rsht_pkg::IDX_W-1:0], v);
			end
			if (ph == 9) quiet = 1'b1;
			for (int n = 0; n < 150; n++) begin
				logic signed [rsht_pkg::DIR_W-1:0] dx, dy, dz;
				int ax, ay, az;
				dx = rand_dir();
				dy = rand_dir();
				dz = rand_dir();
				// Aim about half the rays at the sphere so hits are common.
				if ($urandom_range(0, 1)) begin
					ax = ($signed(sph_regs[rsht_pkg::REG_CENTER_X])
						- $signed(sph_regs[rsht_pkg::REG_ORIGIN_X])) >>> 8;
					ay = ($signed(sph_regs[rsht_pkg::REG_CENTER_Y])
						- $signed(sph_regs[rsht_pkg::REG_ORIGIN_Y])) >>> 8;
					az = ($signed(sph_regs[rsht_pkg::REG_CENTER_Z])
						- $signed(sph_regs[rsht_pkg::REG_ORIGIN_Z])) >>> 8;
					dx = rsht_pkg::DIR_W'(ax + int'($urandom_range(0, 255)) - 128);
					dy = rsht_pkg::DIR_W'(ay);
					dz = rsht_pkg::DIR_W'(az);
				end
				send_ray(dx, dy, dz, -1);
			end
			drain();
		end
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
